// ----- design/orse_pkg.sv -----
// package for the 1-wire rom search engine
// holds widths, status codes, item and state structs, and the crc-8 step
// no dependencies
package orse_pkg;

	localparam int unsigned ROM_BITS = 64;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned IDX_W    = 7;
	localparam int unsigned CRC_W    = 8;

	// dallas crc-8, x^8+x^5+x^4+1, reflected form
	localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

	// request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_BITS  = 1'b1;

	typedef enum logic [1:0] {
		ST_RUNNING = 2'd0,
		ST_VALID   = 2'd1,
		ST_ABORT   = 2'd2,
		ST_BAD     = 2'd3
	} status_t;

	typedef struct packed {
		logic                req_type;
		logic [ROM_BITS-1:0] prev_path;
		logic [IDX_W-1:0]    prev_length;
		logic                id_bit;
		logic                complement_bit;
	} req_t;

	typedef struct packed {
		logic                direction_bit;
		logic                write_valid;
		logic                done_res;
		status_t             status;
		logic [ROM_BITS-1:0] rom_code;
		logic [ROM_BITS-1:0] branch_path;
		logic [POS_W-1:0]    branch_length;
	} rsp_t;

	typedef struct packed {
		logic [ROM_BITS-1:0] path_bits;
		logic [IDX_W-1:0]    bit_index;
		logic [ROM_BITS-1:0] followed_path;
		logic [IDX_W-1:0]    followed_length;
		logic [ROM_BITS-1:0] br_path;
		logic [POS_W-1:0]    br_length;
		logic [CRC_W-1:0]    crc;
		logic                searching;
	} state_t;

	// one serial crc step, lsb first
	function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] crc,
		input logic bit_in);
		logic [CRC_W-1:0] sh;
		sh = crc >> 1;
		if (crc[0] ^ bit_in) begin
			sh = sh ^ CRC_POLY;
		end
		return sh;
	endfunction

endpackage

// ----- design/orse_ifs.sv -----
// valid/ready channel interfaces for the 1-wire rom search engine
// request channel and result channel; depends on orse_pkg
interface orse_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [orse_pkg::ROM_BITS-1:0] prev_path;
	logic [orse_pkg::IDX_W-1:0]    prev_length;
	logic                          id_bit;
	logic                          complement_bit;

	modport source (output valid, req_type, prev_path, prev_length, id_bit, complement_bit,
		input ready);
	modport sink (input valid, req_type, prev_path, prev_length, id_bit, complement_bit,
		output ready);
endinterface

interface orse_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          direction_bit;
	logic                          write_valid;
	logic                          done_res;
	logic [1:0]                    status;
	logic [orse_pkg::ROM_BITS-1:0] rom_code;
	logic [orse_pkg::ROM_BITS-1:0] branch_path;
	logic [orse_pkg::POS_W-1:0]    branch_length;

	modport source (output valid, direction_bit, write_valid, done_res, status, rom_code,
		branch_path, branch_length, input ready);
	modport sink (input valid, direction_bit, write_valid, done_res, status, rom_code,
		branch_path, branch_length, output ready);
endinterface

// ----- design/orse_decide.sv -----
// search decision logic: next search state and result for one request
// purely combinational; depends on orse_pkg
module orse_decide (
	input  orse_pkg::state_t cur,
	input  orse_pkg::req_t   item,
	output orse_pkg::state_t nxt,
	output logic             has_rsp,
	output orse_pkg::rsp_t   rsp
);
	import orse_pkg::*;

	logic [POS_W-1:0]    pos;
	logic                dir;
	logic                branch;
	logic [ROM_BITS-1:0] path_new;
	logic [CRC_W-1:0]    crc_new;
	logic [IDX_W-1:0]    idx_new;
	logic                last;

	// direction choice for the current position
	always_comb begin
		pos    = cur.bit_index[POS_W-1:0];
		branch = 1'b0;
		if (item.id_bit != item.complement_bit) begin
			dir = item.id_bit;
		end else if ({1'b0, pos} < cur.followed_length) begin
			dir = cur.followed_path[pos];
		end else if ({1'b0, pos} == cur.followed_length) begin
			dir = 1'b1;
		end else begin
			dir    = 1'b0;
			branch = 1'b1;
		end
		path_new = cur.path_bits | ({{(ROM_BITS-1){1'b0}}, dir} << pos);
		crc_new  = crc_shift(cur.crc, dir);
		idx_new  = cur.bit_index + IDX_W'(1);
		last     = idx_new[IDX_W-1];
	end

	// state update and result
	always_comb begin
		nxt     = cur;
		has_rsp = 1'b0;
		rsp     = '0;
		if (item.req_type == REQ_START) begin
			nxt.followed_path   = item.prev_path;
			nxt.followed_length = item.prev_length;
			nxt.path_bits       = '0;
			nxt.bit_index       = '0;
			nxt.br_path         = '0;
			nxt.br_length       = '0;
			nxt.crc             = '0;
			nxt.searching       = 1'b1;
		end else if (cur.searching) begin
			has_rsp = 1'b1;
			if (item.id_bit && item.complement_bit) begin
				// no device answered: abort
				nxt.searching = 1'b0;
				rsp.done_res  = 1'b1;
				rsp.status    = ST_ABORT;
			end else begin
				nxt.path_bits = path_new;
				nxt.crc       = crc_new;
				nxt.bit_index = idx_new;
				if (branch) begin
					nxt.br_path   = cur.path_bits;
					nxt.br_length = pos;
				end
				rsp.direction_bit = dir;
				rsp.write_valid   = 1'b1;
				if (last) begin
					// rom complete: reject empty rom or bad crc
					nxt.searching = 1'b0;
					rsp.done_res  = 1'b1;
					if (path_new != '0 && crc_new == '0) begin
						rsp.status        = ST_VALID;
						rsp.rom_code      = path_new;
						rsp.branch_path   = nxt.br_path;
						rsp.branch_length = nxt.br_length;
					end else begin
						rsp.status = ST_BAD;
					end
				end else begin
					rsp.status        = ST_RUNNING;
					rsp.rom_code      = path_new;
					rsp.branch_path   = nxt.br_path;
					rsp.branch_length = nxt.br_length;
				end
			end
		end
	end

endmodule

// ----- design/onewire_rom_search_engine_unit.sv -----
// top level of the 1-wire rom search engine
// input register, decision logic, result register; depends on orse_pkg,
// orse_ifs and orse_decide
//
// Takes one request per clock cycle while no stalled result blocks the held
// request: a start request loads the previous path and length, and each
// bit-pair request returns the direction bit for one rom position. A request
// passes the input register, then its result passes the result register
// around the decision logic, and the result may wait there while the next
// request is accepted. Start requests and bit pairs that arrive while no
// search runs give no result. The last result of a search carries done_res
// and the final status, with the full rom and branch record when the rom is valid.
module onewire_rom_search_engine_unit (
	input logic      clk,
	input logic      arst_n,
	orse_req_if.sink   req,
	orse_rsp_if.source rsp
);
	import orse_pkg::*;

	logic   valid_s1;
	req_t   item_s1;
	state_t state_q;
	state_t state_d;
	logic   has_rsp;
	rsp_t   rsp_d;
	logic   out_valid_q;
	rsp_t   out_q;
	logic   advance;

	orse_decide u_decide (
		.cur     (state_q),
		.item    (item_s1),
		.nxt     (state_d),
		.has_rsp (has_rsp),
		.rsp     (rsp_d)
	);

	// the held request retires when its result has room
	assign advance   = valid_s1 && (!has_rsp || !out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{req_type: req.req_type, prev_path: req.prev_path,
				prev_length: req.prev_length, id_bit: req.id_bit,
				complement_bit: req.complement_bit};
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_rsp) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_rsp) begin
			out_q <= rsp_d;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.direction_bit = out_q.direction_bit;
	assign rsp.write_valid   = out_q.write_valid;
	assign rsp.done_res      = out_q.done_res;
	assign rsp.status        = out_q.status;
	assign rsp.rom_code      = out_q.rom_code;
	assign rsp.branch_path   = out_q.branch_path;
	assign rsp.branch_length = out_q.branch_length;

endmodule

// ----- design/orse_checker.sv -----
// port-level checks on the result channel of the rom search engine
// bound to onewire_rom_search_engine_unit; depends on orse_pkg
module orse_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          write_valid,
	input logic                          done_res,
	input logic [1:0]                    status,
	input logic [orse_pkg::ROM_BITS-1:0] rom_code
);
	import orse_pkg::*;

	// only a running result leaves the search open
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (done_res == (status != ST_RUNNING)))
		else $error("done_res disagrees with status");

	// abort carries no write and no rom
	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_ABORT) |-> (!write_valid && rom_code == '0))
		else $error("abort result carries a write or rom");

	// a valid rom is never empty, and only abort skips the write
	a_valid_rom: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_VALID) |-> (rom_code != '0 && write_valid))
		else $error("valid rom empty or unwritten");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rom_code) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind onewire_rom_search_engine_unit orse_checker u_orse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.write_valid (rsp.write_valid),
	.done_res    (rsp.done_res),
	.status      (rsp.status),
	.rom_code    (rsp.rom_code)
);

// ----- dv/tb.sv -----
// testbench for onewire_rom_search_engine_unit: 1-wire search rom decisions
// emulates a wired-and bus of device roms and checks every result against a predictor
// depends on orse_pkg, orse_ifs and the design top level
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import orse_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	orse_req_if req_ch();
	orse_rsp_if rsp_ch();

	onewire_rom_search_engine_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// predicted search state
	logic [ROM_BITS-1:0] m_path;
	logic [IDX_W-1:0]    m_index;
	logic [ROM_BITS-1:0] m_follow_path;
	logic [IDX_W-1:0]    m_follow_len;
	logic [ROM_BITS-1:0] m_br_path;
	logic [POS_W-1:0]    m_br_len;
	logic [CRC_W-1:0]    m_crc;
	logic                m_active;
	status_t             m_last_status;

	rsp_t                due_answers[$];
	logic [ROM_BITS-1:0] dev_roms[$];
	int                  fail_count = 0;
	int                  items_done = 0;
	bit                  steady = 1'b0;

	// serial dallas crc-8 step, lsb first
	function automatic logic [CRC_W-1:0] crc8_next(input logic [CRC_W-1:0] c, input logic b);
		logic fb;
		fb = c[0] ^ b;
		return {1'b0, c[CRC_W-1:1]} ^ ({CRC_W{fb}} & CRC_POLY);
	endfunction

	// rom with a matching crc byte on top
	function automatic logic [ROM_BITS-1:0] make_rom(input logic [55:0] body);
		logic [CRC_W-1:0] c;
		c = '0;
		for (int i = 0; i < 56; i++) begin
			c = crc8_next(c, body[i]);
		end
		return {c, body};
	endfunction

	function automatic logic [ROM_BITS-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// predicted effect of one accepted request; queues the answer it causes
	task automatic search_step(input req_t r, output bit ignored);
		rsp_t             ans;
		logic [POS_W-1:0] pos;
		logic             dir;
		ignored = 1'b0;
		if (r.req_type == REQ_START) begin
			m_follow_path = r.prev_path;
			m_follow_len  = r.prev_length;
			m_path        = '0;
			m_index       = '0;
			m_br_path     = '0;
			m_br_len      = '0;
			m_crc         = '0;
			m_active      = 1'b1;
		end else if (!m_active) begin
			ignored = 1'b1;
		end else if (r.id_bit && r.complement_bit) begin
			// no device answered: abort
			ans = '0;
			ans.done_res = 1'b1;
			ans.status = ST_ABORT;
			m_active = 1'b0;
			m_last_status = ST_ABORT;
			due_answers.push_back(ans);
		end else begin
			pos = m_index[POS_W-1:0];
			if (r.id_bit != r.complement_bit) begin
				dir = r.id_bit;
			end else if ({1'b0, pos} < m_follow_len) begin
				dir = m_follow_path[pos];
			end else if ({1'b0, pos} == m_follow_len) begin
				dir = 1'b1;
			end else begin
				dir = 1'b0;
				m_br_path = m_path;
				m_br_len = pos;
			end
			m_path[pos] = dir;
			m_crc = crc8_next(m_crc, dir);
			m_index = m_index + 1'b1;
			ans.direction_bit = dir;
			ans.write_valid = 1'b1;
			ans.done_res = 1'b0;
			ans.status = ST_RUNNING;
			ans.rom_code = m_path;
			ans.branch_path = m_br_path;
			ans.branch_length = m_br_len;
			if (m_index >= IDX_W'(ROM_BITS)) begin
				m_active = 1'b0;
				ans.done_res = 1'b1;
				if (m_path != '0 && m_crc == '0) begin
					ans.status = ST_VALID;
				end else begin
					ans.status = ST_BAD;
					ans.rom_code = '0;
					ans.branch_path = '0;
					ans.branch_length = '0;
				end
				m_last_status = ans.status;
			end
			due_answers.push_back(ans);
		end
	endtask

	// one request transfer, with random idle cycles ahead of it unless steady
	task automatic send_item(input req_t r);
		bit ignored;
		while (!steady && $urandom_range(99) < 33) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= r.req_type;
		req_ch.prev_path      <= r.prev_path;
		req_ch.prev_length    <= r.prev_length;
		req_ch.id_bit         <= r.id_bit;
		req_ch.complement_bit <= r.complement_bit;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		search_step(r, ignored);
		if (!ignored) begin
			items_done++;
		end
	endtask

	// start request, bit fields random
	task automatic send_start(input logic [ROM_BITS-1:0] path, input logic [IDX_W-1:0] len);
		req_t r;
		r.req_type = REQ_START;
		r.prev_path = path;
		r.prev_length = len;
		r.id_bit = 1'($urandom);
		r.complement_bit = 1'($urandom);
		send_item(r);
	endtask

	// bit pair request, path fields random
	task automatic send_pair(input logic id, input logic cmp);
		req_t r;
		r.req_type = REQ_BITS;
		r.prev_path = rand64();
		r.prev_length = IDX_W'($urandom);
		r.id_bit = id;
		r.complement_bit = cmp;
		send_item(r);
	endtask

	// wired-and answer of the devices still matching the path taken so far
	function automatic void bus_bits(output logic id, output logic cmp);
		logic [ROM_BITS-1:0] mask;
		int unsigned pos;
		pos = 32'(m_index[POS_W-1:0]);
		mask = (64'd1 << pos) - 64'd1;
		id = 1'b1;
		cmp = 1'b1;
		foreach (dev_roms[k]) begin
			if (((dev_roms[k] ^ m_path) & mask) == '0) begin
				id &= dev_roms[k][pos];
				cmp &= ~dev_roms[k][pos];
			end
		end
	endfunction

	// one search pass over the bus, sometimes disturbed or left unfinished
	task automatic run_search(input logic [ROM_BITS-1:0] path, input logic [IDX_W-1:0] len);
		logic id;
		logic cmp;
		send_start(path, len);
		for (int p = 0; p < ROM_BITS; p++) begin
			if (!m_active || $urandom_range(199) == 0) begin
				return;
			end
			bus_bits(id, cmp);
			if ($urandom_range(99) < 3) begin
				id = 1'($urandom);
				cmp = 1'($urandom);
			end
			send_pair(id, cmp);
		end
	endtask

	// fill the bus with a random set of devices
	task automatic build_bus();
		int unsigned n;
		int unsigned kind;
		logic [ROM_BITS-1:0] rom;
		dev_roms.delete();
		n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				rom = make_rom({$urandom, 24'($urandom_range(0, 16777215))});
			end else if (kind < 82) begin
				rom = rand64();
			end else if (kind < 90) begin
				rom = '0;
			end else if (dev_roms.size() != 0) begin
				// near twin of the first device: long shared prefix
				rom = dev_roms[0];
				rom[$urandom_range(30, 55)] ^= 1'b1;
				rom = make_rom(rom[55:0]);
			end else begin
				rom = make_rom({32'hFFFF_FFFF, 24'hFFFFFF});
			end
			dev_roms.push_back(rom);
		end
	endtask

	// enumerate the bus by feeding each branch record into the next search
	task automatic enumerate_bus();
		logic [ROM_BITS-1:0] path;
		logic [IDX_W-1:0]    len;
		build_bus();
		path = rand64();
		len = ($urandom_range(3) == 0) ? IDX_W'($urandom) : '0;
		for (int s = 0; s < 6; s++) begin
			run_search(path, len);
			if (m_active || m_last_status != ST_VALID || m_br_len == '0) begin
				break;
			end
			path = m_br_path;
			len = {1'b0, m_br_len};
		end
	endtask

	// unstructured requests
	task automatic noise_burst();
		req_t r;
		repeat ($urandom_range(3, 15)) begin
			r.req_type = ($urandom_range(99) < 20) ? REQ_START : REQ_BITS;
			r.prev_path = rand64();
			r.prev_length = IDX_W'($urandom);
			r.id_bit = 1'($urandom);
			r.complement_bit = 1'($urandom);
			send_item(r);
		end
	endtask

	// bit pairs with no search running are dropped
	task automatic test_idle_pairs();
		send_pair(1'b0, 1'b0);
		send_pair(1'b1, 1'b1);
	endtask

	// long previous length follows the whole path; both ones aborts
	task automatic test_follow_and_abort();
		send_start('1, 7'h7F);
		send_pair(1'b0, 1'b0);
		send_pair(1'b1, 1'b0);
		send_pair(1'b0, 1'b1);
		send_pair(1'b0, 1'b0);
		send_pair(1'b1, 1'b1);
		send_pair(1'b0, 1'b1);
	endtask

	// one at the previous length, zero and a branch record beyond it, restarts
	task automatic test_branch_rules();
		send_start(rand64(), 7'd0);
		send_pair(1'b0, 1'b0);
		send_pair(1'b0, 1'b0);
		send_pair(1'b0, 1'b0);
		send_start('0, 7'd64);
		send_pair(1'b0, 1'b0);
		send_pair(1'b1, 1'b0);
		send_start(64'h5555_5555_5555_5556, 7'd2);
		send_pair(1'b0, 1'b0);
		send_pair(1'b0, 1'b0);
		send_pair(1'b0, 1'b0);
		send_pair(1'b0, 1'b0);
		send_pair(1'b1, 1'b1);
	endtask

	// bus searches mixed with noise until the item count is reached
	task automatic test_search_traffic(input int target);
		while (items_done < target) begin
			if ($urandom_range(99) < 15) begin
				noise_burst();
			end else begin
				enumerate_bus();
			end
		end
	endtask

	// compare one result field
	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// result transfers against the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_answers.size() == 0) begin
				$error("result transfer with no prediction outstanding");
				fail_count++;
			end else begin
				want = due_answers.pop_front();
				check_field("direction_bit", 64'(want.direction_bit),
					64'(rsp_ch.direction_bit));
				check_field("write_valid", 64'(want.write_valid), 64'(rsp_ch.write_valid));
				check_field("done_res", 64'(want.done_res), 64'(rsp_ch.done_res));
				check_field("status", 64'(want.status), 64'(rsp_ch.status));
				check_field("rom_code", want.rom_code, rsp_ch.rom_code);
				check_field("branch_path", want.branch_path, rsp_ch.branch_path);
				check_field("branch_length", 64'(want.branch_length),
					64'(rsp_ch.branch_length));
			end
		end
	end

	// result side back-pressure
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= steady || ($urandom_range(99) >= 33);
		end
	end

	// hard stop
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		req_ch.valid          <= 1'b0;
		req_ch.req_type       <= REQ_BITS;
		req_ch.prev_path      <= '0;
		req_ch.prev_length    <= '0;
		req_ch.id_bit         <= 1'b0;
		req_ch.complement_bit <= 1'b0;
		m_path        = '0;
		m_index       = '0;
		m_follow_path = '0;
		m_follow_len  = '0;
		m_br_path     = '0;
		m_br_len      = '0;
		m_crc         = '0;
		m_active      = 1'b0;
		m_last_status = ST_RUNNING;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_pairs();
		test_follow_and_abort();
		test_branch_rules();
		steady = 1'b1;
		test_search_traffic(700);
		steady = 1'b0;
		test_search_traffic(1900);

		// drain
		req_ch.valid <= 1'b0;
		for (int n = 0; n < 5000 && due_answers.size() != 0; n++) begin
			@(posedge clk);
		end
		if (due_answers.size() != 0) begin
			$error("%0d predicted results never arrived", due_answers.size());
			fail_count++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
